// ===== rtl/core/xxtea_block_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// XXTEA block cipher assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XXTEA_BLOCK_CIPHER_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_MACROS_SVH

`ifndef ASSERT_OFF
`define XXTEA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define XXTEA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define XXTEA_ASSERT(lbl, cond, msg)
`define XXTEA_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/xxtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XXTEA package
// Register indexes, cipher constants, round table and the mixing function.
// ----------------------------------------------------------------------------
package xxtea_pkg;

	typedef logic [31:0] word_t;
	typedef logic [2:0]  reg_idx_t;
	typedef logic [5:0]  rounds_t;

	localparam reg_idx_t REG_KEY0 = 3'd0;
	localparam reg_idx_t REG_KEY1 = 3'd1;
	localparam reg_idx_t REG_KEY2 = 3'd2;
	localparam reg_idx_t REG_KEY3 = 3'd3;
	localparam reg_idx_t REG_MODE = 3'd4;

	localparam word_t DELTA = 32'h9e37_79b9;

	// 6 + 52/n for block sizes up to 127 words
	function automatic rounds_t rounds_for(input logic [6:0] n);
		rounds_t r;
		if (n <= 7'd1)
			r = 6'd58;
		else if (n == 7'd2)
			r = 6'd32;
		else if (n == 7'd3)
			r = 6'd23;
		else if (n == 7'd4)
			r = 6'd19;
		else if (n == 7'd5)
			r = 6'd16;
		else if (n == 7'd6)
			r = 6'd14;
		else if (n == 7'd7)
			r = 6'd13;
		else if (n == 7'd8)
			r = 6'd12;
		else if (n <= 7'd10)
			r = 6'd11;
		else if (n <= 7'd13)
			r = 6'd10;
		else if (n <= 7'd17)
			r = 6'd9;
		else if (n <= 7'd26)
			r = 6'd8;
		else if (n <= 7'd52)
			r = 6'd7;
		else
			r = 6'd6;
		return r;
	endfunction

	function automatic word_t mix(input word_t y, input word_t z, input word_t sum,
		input word_t key);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		a = (z >> 5) ^ (y << 2);
		b = (y >> 3) ^ (z << 4);
		c = sum ^ y;
		d = key ^ z;
		return (a + b) ^ (c + d);
	endfunction

endpackage

// ===== rtl/core/xxtea_ram.sv =====
// ----------------------------------------------------------------------------
// XXTEA word RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module xxtea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/xxtea_block_cipher.sv =====
// Words load in idle, the only state taking input; S_RD_Z, S_RD_C, S_RD_F
// then precede R*n word updates in S_RUN (R = 6 + 52/n), one word update per
// cycle through the single RAM read port and write port. Each word is emitted
// by a RAM read (S_ER, held on a stalled output) and an output register load
// (S_EL). A one-word block skips the rounds. Reset clears control state and
// keys; the word RAM is undefined until loaded and needs no clearing pass.
// ----------------------------------------------------------------------------
// XXTEA block cipher
// Loads a block word by word, runs the corrected block TEA rounds in place
// in a word RAM, and streams the processed words out.
// ----------------------------------------------------------------------------
`include "xxtea_block_cipher_macros.svh"

module xxtea_block_cipher #(
	parameter int MAX_WORDS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// config write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  xxtea_pkg::reg_idx_t       cfg_index,
	input  xxtea_pkg::word_t          cfg_data,
	// input item stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // [31:0] data_word
	input  logic                      s_tlast,   // last_word
	// result item stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // [31:0] result_word
	output logic                      m_tlast,   // result_last
	output logic                      m_tuser    // [0] overflow
);

	import xxtea_pkg::*;

	localparam int AW = $clog2(MAX_WORDS);
	localparam int CW = $clog2(MAX_WORDS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD_Z  = 3'd1;
	localparam logic [2:0] S_RD_C  = 3'd2;
	localparam logic [2:0] S_RD_F  = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_ER    = 3'd5;
	localparam logic [2:0] S_EL    = 3'd6;

	logic [2:0]    state_q;
	word_t         key_q [4];
	logic          dec_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	rounds_t       rounds_q;
	word_t         sum_q;
	word_t         z_q;
	word_t         cur_q;
	logic [AW-1:0] p_q;
	logic [AW-1:0] ra_q;
	logic          fwd_q;
	word_t         fwd_data_q;
	logic          m_tvalid_q;
	word_t         m_tdata_q;
	logic          m_tlast_q;
	logic          m_tuser_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	word_t         ram_wdata;
	logic [AW-1:0] ram_raddr;
	word_t         ram_rdata;
	word_t         rdx;
	word_t         key_cur;
	word_t         mix_val;
	word_t         v_new;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] ra_next;
	logic [AW-1:0] p_next;
	logic          round_end;
	logic          full;
	logic          in_acc;
	logic [CW-1:0] count_next;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;
	assign m_tuser   = m_tuser_q;

	assign last_idx   = AW'(count_q - CW'(1));
	assign full       = (count_q == CW'(MAX_WORDS));
	assign count_next = full ? count_q : count_q + CW'(1);
	assign rdx        = fwd_q ? fwd_data_q : ram_rdata;

	always_comb begin
		unique case (2'(p_q) ^ sum_q[3:2])
			2'd0:    key_cur = key_q[0];
			2'd1:    key_cur = key_q[1];
			2'd2:    key_cur = key_q[2];
			default: key_cur = key_q[3];
		endcase
	end

	always_comb begin
		if (dec_q) begin
			mix_val = mix(z_q, rdx, sum_q, key_cur);
			v_new   = cur_q - mix_val;
		end else begin
			mix_val = mix(rdx, z_q, sum_q, key_cur);
			v_new   = cur_q + mix_val;
		end
	end

	always_comb begin
		if (dec_q) begin
			ra_next   = (ra_q == '0) ? last_idx : ra_q - AW'(1);
			p_next    = (p_q == '0) ? last_idx : p_q - AW'(1);
			round_end = (p_q == '0);
		end else begin
			ra_next   = (ra_q == last_idx) ? '0 : ra_q + AW'(1);
			p_next    = (p_q == last_idx) ? '0 : p_q + AW'(1);
			round_end = (p_q == last_idx);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = p_q;
		ram_wdata = v_new;
		if (state_q == S_IDLE && in_acc && !full) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = s_tdata;
		end else if (state_q == S_RUN) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		unique case (state_q)
			S_RD_Z:         ram_raddr = dec_q ? '0 : last_idx;
			S_RD_C:         ram_raddr = dec_q ? last_idx : '0;
			S_RD_F, S_RUN:  ram_raddr = ra_q;
			default:        ram_raddr = p_q;
		endcase
	end

	xxtea_ram #(
		.WIDTH (32),
		.DEPTH (MAX_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
			dec_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				REG_MODE: dec_q    <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			rounds_q   <= '0;
			sum_q      <= '0;
			z_q        <= '0;
			cur_q      <= '0;
			p_q        <= '0;
			ra_q       <= '0;
			fwd_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			fwd_q <= ram_we && (ram_waddr == ram_raddr);
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						count_q <= count_next;
						if (full)
							ovf_q <= 1'b1;
						if (s_tlast) begin
							p_q     <= '0;
							state_q <= (count_next == CW'(1)) ? S_ER : S_RD_Z;
						end
					end
				end
				S_RD_Z: begin
					rounds_q <= rounds_for(7'(count_q));
					state_q  <= S_RD_C;
				end
				S_RD_C: begin
					z_q     <= rdx;
					sum_q   <= dec_q ? 32'(32'(rounds_q) * DELTA) : DELTA;
					p_q     <= dec_q ? last_idx : '0;
					ra_q    <= dec_q ? last_idx - AW'(1) : AW'(1);
					state_q <= S_RD_F;
				end
				S_RD_F: begin
					cur_q   <= rdx;
					ra_q    <= ra_next;
					state_q <= S_RUN;
				end
				S_RUN: begin
					z_q   <= v_new;
					cur_q <= rdx;
					ra_q  <= ra_next;
					if (round_end && rounds_q == 6'd1) begin
						p_q     <= '0;
						state_q <= S_ER;
					end else begin
						p_q <= p_next;
					end
					if (round_end) begin
						sum_q    <= dec_q ? sum_q - DELTA : sum_q + DELTA;
						rounds_q <= rounds_q - 6'd1;
					end
				end
				S_ER: begin
					if (!m_tvalid_q || m_tready)
						state_q <= S_EL;
				end
				S_EL: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= rdx;
					m_tlast_q  <= (p_q == last_idx);
					m_tuser_q  <= ovf_q;
					if (p_q == last_idx) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						p_q     <= p_q + AW'(1);
						state_q <= S_ER;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`XXTEA_ASSERT(a_count_bound, count_q <= CW'(MAX_WORDS), "word count above capacity")
	`XXTEA_ASSERT_IMP(a_run_size, state_q == S_RUN, count_q >= CW'(2), "rounds on short block")
	`XXTEA_ASSERT_IMP(a_out_free, state_q == S_EL, !m_tvalid_q, "output register overwritten")

endmodule
